/* design/mipag_pkg.sv */
package mipag_pkg;

   // Geometry of the atlas
   localparam int TILE_BLOCKS    = 8;
   localparam int BLOCK_BYTES    = 8;
   localparam int MIP_LEVELS     = 4;
   localparam int MAX_TILES_SIDE = 64;
   localparam int BLK_TEXELS     = 4;
   localparam int BLK_SHIFT      = 2;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Port field widths
   localparam int MAP_W    = 7;
   localparam int CAP_W    = 23;
   localparam int CSR_W    = 23;
   localparam int IDX_W    = 2;
   localparam int MIP_W    = 2;
   localparam int TILE_W   = 6;
   localparam int STATUS_W = 2;
   localparam int OFFSET_W = 22;
   localparam int SRC_W    = 9;
   localparam int LEN_W    = 7;

   // Internal widths
   localparam int SIDE_W    = 9;
   localparam int TEX_W     = 16;
   localparam int BLK_W     = 14;
   localparam int PROD_W    = 2 * BLK_W;
   localparam int ACC_W     = 36;
   localparam int ROWB_W    = BLK_W + 5;
   localparam int BLKS_W    = $clog2(TILE_BLOCKS + 1);
   localparam int ROW_W     = (TILE_BLOCKS > 1) ? $clog2(TILE_BLOCKS) : 1;
   localparam int COPY_W    = BLKS_W + 5;
   localparam int ROWM_W    = TILE_W + BLKS_W;
   localparam int MUL_W     = ROWM_W + ROWB_W;
   localparam int CC_W      = TILE_W + COPY_W;
   localparam int SRCA_W    = ROW_W + COPY_W;
   localparam int LVL_W     = (MIP_LEVELS > 1) ? $clog2(MIP_LEVELS) : 1;
   localparam int LVL_SLOTS = 1 << MIP_W;

   // Configuration register indexes
   typedef enum logic [IDX_W-1:0] {
      CSR_MAP_WIDE = 2'd0,
      CSR_MAP_DEEP = 2'd1,
      CSR_BYTE_CAP = 2'd2
   } csr_index_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_COPY     = 2'd0,
      ST_OVER_CAP = 2'd1,
      ST_OUTSIDE  = 2'd2
   } status_type;

   // Kind of work queued for the back end
   typedef enum logic [1:0] {
      KIND_COPY,
      KIND_CAP,
      KIND_MAP
   } kind_type;

   typedef enum logic [1:0] {
      RC_MUL,
      RC_ACC,
      RC_READY
   } rc_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL1,
      BK_MUL2,
      BK_SUM,
      BK_ROWS
   } bk_state_type;

   typedef struct packed {
      kind_type          kind;
      logic [MIP_W-1:0]  level;
      logic [TILE_W-1:0] col;
      logic [TILE_W-1:0] row;
   } queue_entry_type;

   // Layout derived from the map size
   typedef struct packed {
      logic [LVL_SLOTS-1:0][ACC_W-1:0]  base;
      logic [LVL_SLOTS-1:0][ROWB_W-1:0] rowb;
      logic [ACC_W-1:0]                 total;
   } layout_type;

   function automatic logic [SIDE_W-1:0] side_clamp(input logic [MAP_W-1:0] v);
      logic [SIDE_W-1:0] s;
      s = SIDE_W'(v);
      if (s > SIDE_W'(MAX_TILES_SIDE)) s = SIDE_W'(MAX_TILES_SIDE);
      return s;
   endfunction

   // Blocks covering a span of tiles at a level, at least one texel
   function automatic logic [BLK_W-1:0] blocks_across(input logic [SIDE_W-1:0] tiles,
                                                      input logic [LVL_W-1:0]  lvl);
      logic [TEX_W-1:0] tex;
      tex = (TEX_W'(tiles) * TEX_W'(TILE_BLOCKS * BLK_TEXELS)) >> lvl;
      if (tex == '0) tex = TEX_W'(1);
      tex = tex + TEX_W'(BLK_TEXELS - 1);
      return BLK_W'(tex >> BLK_SHIFT);
   endfunction

   // Block rows of one tile at a level
   function automatic logic [BLKS_W-1:0] level_blocks(input logic [MIP_W-1:0] lvl);
      return BLKS_W'(TILE_BLOCKS >> lvl);
   endfunction

endpackage

/* design/mip_atlas_copy_address_generator.sv */
// Copy address generator for a block-compressed, mip-chained tile atlas. The map size in
// tiles (csr index 0 and 1) sets the atlas layout and the byte cap (index 2) bounds it; after
// reset and after every write to index 0, 1 or 2 a layout sequencer steps a multiply state
// and an accumulate state for each mip level, computing level bases and the total, and
// req_ready stays low meanwhile. Each request word names a tile and a mip level; a present
// tile yields one copy descriptor per block row that fits inside the atlas, last_row marking
// the final one, an absent tile yields nothing, and an over-cap atlas or a tile outside the
// map yields a single error word. The front end classifies a word combinationally and
// queues it; the back end sets up the address in BK_MUL1, BK_MUL2 and BK_SUM (two registered
// multiplies and a sum) and then emits one descriptor per cycle from its row stepper while
// the result side is not stalled.
module mip_atlas_copy_address_generator import mipag_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]    csr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [MIP_W-1:0]    req_mip_level,
   input  logic [TILE_W-1:0]   req_tile_column,
   input  logic [TILE_W-1:0]   req_tile_row,
   input  logic                req_tile_present,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [OFFSET_W-1:0] rsp_atlas_offset,
   output logic [SRC_W-1:0]    rsp_source_offset,
   output logic [LEN_W-1:0]    rsp_copy_length,
   output logic                rsp_last_row
);

   logic            queue_full;
   logic            push;
   queue_entry_type push_entry;
   logic            pop;
   logic            head_valid;
   queue_entry_type head_entry;
   layout_type      layout;

   // Classify words and keep the layout
   mipag_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mip_level    (req_mip_level),
      .req_tile_column  (req_tile_column),
      .req_tile_row     (req_tile_row),
      .req_tile_present (req_tile_present),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry),
      .layout           (layout)
   );

   // Decouple front and back
   mipag_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Emit descriptors
   mipag_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_entry        (head_entry),
      .pop               (pop),
      .layout            (layout),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_atlas_offset  (rsp_atlas_offset),
      .rsp_source_offset (rsp_source_offset),
      .rsp_copy_length   (rsp_copy_length),
      .rsp_last_row      (rsp_last_row)
   );

endmodule

/* design/mipag_queue.sv */
module mipag_queue import mipag_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output logic            head_valid,
   output queue_entry_type head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type  slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued words
   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

/* design/mipag_front.sv */
module mipag_front import mipag_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]  csr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [MIP_W-1:0]  req_mip_level,
   input  logic [TILE_W-1:0] req_tile_column,
   input  logic [TILE_W-1:0] req_tile_row,
   input  logic              req_tile_present,
   input  logic              queue_full,
   output logic              push,
   output queue_entry_type   push_entry,
   output layout_type        layout
);

   logic [MAP_W-1:0]  wide_ff, wide_in;
   logic [MAP_W-1:0]  deep_ff, deep_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   rc_state_type      rc_state_ff, rc_state_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   layout_type        layout_ff, layout_in;

   logic [BLK_W-1:0]  wblk, dblk;
   logic [SIDE_W-1:0] side_wide, side_deep;
   logic              over_cap, outside, level_ok;

   assign side_wide = side_clamp(wide_ff);
   assign side_deep = side_clamp(deep_ff);
   assign wblk      = blocks_across(side_wide, lvl_ff);
   assign dblk      = blocks_across(side_deep, lvl_ff);
   assign layout    = layout_ff;

   // Write configuration and step the layout sequencer
   always_comb begin
      wide_in     = wide_ff;
      deep_in     = deep_ff;
      cap_in      = cap_ff;
      rc_state_in = rc_state_ff;
      lvl_in      = lvl_ff;
      acc_in      = acc_ff;
      prod_in     = prod_ff;
      layout_in   = layout_ff;
      case (rc_state_ff)
         RC_MUL: begin
            prod_in = PROD_W'(wblk) * PROD_W'(dblk);
            if (int'(lvl_ff) < LVL_SLOTS)
               layout_in.rowb[MIP_W'(lvl_ff)] = ROWB_W'(wblk) * ROWB_W'(BLOCK_BYTES);
            rc_state_in = RC_ACC;
         end
         RC_ACC: begin
            if (int'(lvl_ff) < LVL_SLOTS) layout_in.base[MIP_W'(lvl_ff)] = acc_ff;
            acc_in = acc_ff + ACC_W'(prod_ff) * ACC_W'(BLOCK_BYTES);
            if (lvl_ff == LVL_W'(MIP_LEVELS - 1)) begin
               layout_in.total = acc_in;
               rc_state_in     = RC_READY;
            end else begin
               lvl_in      = lvl_ff + LVL_W'(1);
               rc_state_in = RC_MUL;
            end
         end
         default: ;
      endcase
      if (csr_write) begin
         case (csr_index)
            CSR_MAP_WIDE: wide_in = csr_data[MAP_W-1:0];
            CSR_MAP_DEEP: deep_in = csr_data[MAP_W-1:0];
            CSR_BYTE_CAP: cap_in  = csr_data[CAP_W-1:0];
            default: ;
         endcase
         if (csr_index == CSR_MAP_WIDE || csr_index == CSR_MAP_DEEP ||
             csr_index == CSR_BYTE_CAP) begin
            rc_state_in = RC_MUL;
            lvl_in      = '0;
            acc_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff     <= MAP_W'(1);
         deep_ff     <= MAP_W'(1);
         cap_ff      <= CAP_W'(4194304);
         rc_state_ff <= RC_MUL;
         lvl_ff      <= '0;
         acc_ff      <= '0;
      end else begin
         wide_ff     <= wide_in;
         deep_ff     <= deep_in;
         cap_ff      <= cap_in;
         rc_state_ff <= rc_state_in;
         lvl_ff      <= lvl_in;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      layout_ff <= layout_in;
   end

   // Classify the incoming word
   assign over_cap = layout_ff.total > ACC_W'(cap_ff);
   assign outside  = (SIDE_W'(req_tile_column) >= side_wide) ||
                     (SIDE_W'(req_tile_row) >= side_deep);
   assign level_ok = (int'(req_mip_level) < MIP_LEVELS) &&
                     (level_blocks(req_mip_level) != '0);

   assign req_ready = (rc_state_ff == RC_READY) && !queue_full;

   always_comb begin
      push             = req_valid && req_ready &&
                         (over_cap || outside || (req_tile_present && level_ok));
      push_entry.kind  = over_cap ? KIND_CAP : (outside ? KIND_MAP : KIND_COPY);
      push_entry.level = req_mip_level;
      push_entry.col   = req_tile_column;
      push_entry.row   = req_tile_row;
   end

endmodule

/* design/mipag_back.sv */
module mipag_back import mipag_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  queue_entry_type     head_entry,
   output logic                pop,
   input  layout_type          layout,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [OFFSET_W-1:0] rsp_atlas_offset,
   output logic [SRC_W-1:0]    rsp_source_offset,
   output logic [LEN_W-1:0]    rsp_copy_length,
   output logic                rsp_last_row
);

   bk_state_type      state_ff, state_in;
   logic [MIP_W-1:0]  level_ff, level_in;
   logic [TILE_W-1:0] col_ff, col_in;
   logic [TILE_W-1:0] trow_ff, trow_in;
   logic [BLKS_W-1:0] blocks_ff, blocks_in;
   logic [COPY_W-1:0] copy_ff, copy_in;
   logic [ROW_W-1:0]  row_counter_ff, row_counter_in;
   logic [ROWM_W-1:0] t1_ff, t1_in;
   logic [CC_W-1:0]   cc_ff, cc_in;
   logic [MUL_W-1:0]  m_ff, m_in;
   logic [ACC_W-1:0]  dst_ff, dst_in;
   logic [SRCA_W-1:0] src_ff, src_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [SRC_W-1:0]    srco_ff, srco_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic                last_ff, last_in;

   logic              slot_free;
   logic [ACC_W-1:0]  rowb, row_end;
   logic              fits, next_fits, is_last;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rowb      = ACC_W'(layout.rowb[level_ff]);
   assign row_end   = dst_ff + ACC_W'(copy_ff);
   assign fits      = row_end <= layout.total;
   assign next_fits = (row_end + rowb) <= layout.total;
   assign is_last   = (row_counter_ff == ROW_W'(blocks_ff - BLKS_W'(1))) || !next_fits;

   // Drain the queue and step through block rows
   always_comb begin
      state_in       = state_ff;
      level_in       = level_ff;
      col_in         = col_ff;
      trow_in        = trow_ff;
      blocks_in      = blocks_ff;
      copy_in        = copy_ff;
      row_counter_in = row_counter_ff;
      t1_in          = t1_ff;
      cc_in          = cc_ff;
      m_in           = m_ff;
      dst_in         = dst_ff;
      src_in         = src_ff;
      pop            = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      status_in      = status_ff;
      offset_in      = offset_ff;
      srco_in        = srco_ff;
      len_in         = len_ff;
      last_in        = last_ff;
      case (state_ff)
         BK_IDLE: begin
            if (head_valid) begin
               if (head_entry.kind == KIND_COPY) begin
                  pop       = 1'b1;
                  level_in  = head_entry.level;
                  col_in    = head_entry.col;
                  trow_in   = head_entry.row;
                  blocks_in = level_blocks(head_entry.level);
                  copy_in   = COPY_W'(level_blocks(head_entry.level)) *
                              COPY_W'(BLOCK_BYTES);
                  state_in  = BK_MUL1;
               end else if (slot_free) begin
                  pop          = 1'b1;
                  rsp_valid_in = 1'b1;
                  status_in    = (head_entry.kind == KIND_CAP) ? ST_OVER_CAP : ST_OUTSIDE;
                  offset_in    = '0;
                  srco_in      = '0;
                  len_in       = '0;
                  last_in      = 1'b1;
               end
            end
         end
         BK_MUL1: begin
            t1_in    = ROWM_W'(trow_ff) * ROWM_W'(blocks_ff);
            cc_in    = CC_W'(col_ff) * CC_W'(copy_ff);
            state_in = BK_MUL2;
         end
         BK_MUL2: begin
            m_in     = MUL_W'(t1_ff) * MUL_W'(layout.rowb[level_ff]);
            state_in = BK_SUM;
         end
         BK_SUM: begin
            dst_in         = layout.base[level_ff] + ACC_W'(m_ff) + ACC_W'(cc_ff);
            src_in         = '0;
            row_counter_in = '0;
            state_in       = BK_ROWS;
         end
         BK_ROWS: begin
            if (!fits) begin
               state_in = BK_IDLE;
            end else if (slot_free) begin
               rsp_valid_in   = 1'b1;
               status_in      = ST_COPY;
               offset_in      = dst_ff[OFFSET_W-1:0];
               srco_in        = src_ff[SRC_W-1:0];
               len_in         = copy_ff[LEN_W-1:0];
               last_in        = is_last;
               dst_in         = dst_ff + rowb;
               src_in         = src_ff + SRCA_W'(copy_ff);
               row_counter_in = row_counter_ff + ROW_W'(1);
               if (is_last) state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= BK_IDLE;
         row_counter_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         row_counter_ff <= row_counter_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff  <= level_in;
      col_ff    <= col_in;
      trow_ff   <= trow_in;
      blocks_ff <= blocks_in;
      copy_ff   <= copy_in;
      t1_ff     <= t1_in;
      cc_ff     <= cc_in;
      m_ff      <= m_in;
      dst_ff    <= dst_in;
      src_ff    <= src_in;
      status_ff <= status_in;
      offset_ff <= offset_in;
      srco_ff   <= srco_in;
      len_ff    <= len_in;
      last_ff   <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_atlas_offset  = offset_ff;
   assign rsp_source_offset = srco_ff;
   assign rsp_copy_length   = len_ff;
   assign rsp_last_row      = last_ff;

endmodule

/* test/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mipag_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int RESET_CYCLES = 6;
   localparam int SETTLE_GAP   = 32;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SHOW_LIMIT   = 10;
   localparam int DEFAULT_CAP  = 4194304;
   localparam int FULL_CAP     = 8388607;

   typedef enum int {
      IDLE_MIXED,
      IDLE_SWAPPED,
      IDLE_NONE
   } idle_mode_type;

   typedef struct packed {
      status_type          status;
      logic [OFFSET_W-1:0] atlas_offset;
      logic [SRC_W-1:0]    source_offset;
      logic [LEN_W-1:0]    copy_length;
      logic                last_row;
   } copy_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write = 1'b0;
   logic [IDX_W-1:0]    csr_index = '0;
   logic [CSR_W-1:0]    csr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [MIP_W-1:0]    req_mip_level = '0;
   logic [TILE_W-1:0]   req_tile_column = '0;
   logic [TILE_W-1:0]   req_tile_row = '0;
   logic                req_tile_present = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [OFFSET_W-1:0] rsp_atlas_offset;
   logic [SRC_W-1:0]    rsp_source_offset;
   logic [LEN_W-1:0]    rsp_copy_length;
   logic                rsp_last_row;

   // Shadow copy of the map registers and the layout derived from them
   logic [MAP_W-1:0] map_wide = 7'd1;
   logic [MAP_W-1:0] map_deep = 7'd1;
   logic [CAP_W-1:0] byte_cap = CAP_W'(DEFAULT_CAP);
   int unsigned      level_base [MIP_LEVELS];
   int unsigned      level_row_bytes [MIP_LEVELS];
   int unsigned      atlas_total;

   copy_row_type pending_rows[$];
   int           mismatch_count = 0;
   int unsigned  sender_idle_pct = 0;
   int unsigned  receiver_idle_pct = 0;
   int           hold_off_cycles = 0;
   int           cycle_count = 0;

   mip_atlas_copy_address_generator u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mip_level     (req_mip_level),
      .req_tile_column   (req_tile_column),
      .req_tile_row      (req_tile_row),
      .req_tile_present  (req_tile_present),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_atlas_offset  (rsp_atlas_offset),
      .rsp_source_offset (rsp_source_offset),
      .rsp_copy_length   (rsp_copy_length),
      .rsp_last_row      (rsp_last_row)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Map registers above the largest side count as the largest side
   function automatic int unsigned clamp_side(input logic [MAP_W-1:0] v);
      return (v > MAX_TILES_SIDE) ? MAX_TILES_SIDE : int'(v);
   endfunction

   // Blocks that cover a span of tiles at one mip level, never less than one texel
   function automatic int unsigned span_blocks(input int unsigned tiles, input int unsigned lvl);
      int unsigned texels;
      texels = (tiles * TILE_BLOCKS * BLK_TEXELS) >> lvl;
      if (texels == 0) texels = 1;
      return (texels + BLK_TEXELS - 1) / BLK_TEXELS;
   endfunction

   // Lay the levels out back to back and total them
   function automatic void refresh_layout();
      int unsigned acc;
      acc = 0;
      for (int l = 0; l < MIP_LEVELS; l++) begin
         level_base[l]      = acc;
         level_row_bytes[l] = span_blocks(clamp_side(map_wide), l) * BLOCK_BYTES;
         acc += level_row_bytes[l] * span_blocks(clamp_side(map_deep), l);
      end
      atlas_total = acc;
   endfunction

   function automatic void push_error(input status_type st);
      copy_row_type entry;
      entry = '{status: st, atlas_offset: '0, source_offset: '0, copy_length: '0,
                last_row: 1'b1};
      pending_rows.push_back(entry);
   endfunction

   // Work out the copy descriptors that one tile word produces
   function automatic void predict_tile_copies(input logic [MIP_W-1:0] lvl,
                                               input logic [TILE_W-1:0] col,
                                               input logic [TILE_W-1:0] row,
                                               input logic present);
      copy_row_type rows [TILE_BLOCKS];
      int unsigned  nblk, copy, dst, found;
      if (atlas_total > byte_cap) begin
         push_error(ST_OVER_CAP);
         return;
      end
      if (col >= clamp_side(map_wide) || row >= clamp_side(map_deep)) begin
         push_error(ST_OUTSIDE);
         return;
      end
      if (!present || lvl >= MIP_LEVELS) return;
      nblk  = TILE_BLOCKS >> lvl;
      copy  = nblk * BLOCK_BYTES;
      found = 0;
      for (int unsigned r = 0; r < nblk; r++) begin
         dst = level_base[lvl] + (row * nblk + r) * level_row_bytes[lvl] + col * copy;
         // drop rows that would run past the end of the atlas
         if (dst + copy > atlas_total) continue;
         rows[found] = '{status: ST_COPY, atlas_offset: OFFSET_W'(dst),
                         source_offset: SRC_W'(r * copy), copy_length: LEN_W'(copy),
                         last_row: 1'b0};
         found++;
      end
      if (found > 0) rows[found-1].last_row = 1'b1;
      for (int unsigned k = 0; k < found; k++) pending_rows.push_back(rows[k]);
   endfunction

   // Receiver: long hold-off first, else stall at the configured rate
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // Compare each accepted result word with the oldest predicted one
   always @(posedge clock) begin : rsp_check
      copy_row_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rows.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_LIMIT)
               $display("unexpected word: status %0d atlas %0d src %0d len %0d last %0d",
                        rsp_status, rsp_atlas_offset, rsp_source_offset,
                        rsp_copy_length, rsp_last_row);
         end else begin
            want = pending_rows.pop_front();
            if (rsp_status !== want.status || rsp_atlas_offset !== want.atlas_offset ||
                rsp_source_offset !== want.source_offset ||
                rsp_copy_length !== want.copy_length || rsp_last_row !== want.last_row) begin
               mismatch_count++;
               if (mismatch_count <= SHOW_LIMIT)
                  $display("mismatch: want st %0d atlas %0d src %0d len %0d last %0d, %s",
                           want.status, want.atlas_offset, want.source_offset,
                           want.copy_length, want.last_row,
                           $sformatf("got st %0d atlas %0d src %0d len %0d last %0d",
                                     rsp_status, rsp_atlas_offset, rsp_source_offset,
                                     rsp_copy_length, rsp_last_row));
            end
         end
      end
   end

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_MIXED: begin
            sender_idle_pct   = 38;
            receiver_idle_pct = 57;
         end
         IDLE_SWAPPED: begin
            sender_idle_pct   = 57;
            receiver_idle_pct = 38;
         end
         default: begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
      endcase
   endtask

   // Offer one tile word, hold it until accepted, then predict its results
   task automatic send_tile(input logic [MIP_W-1:0] lvl, input logic [TILE_W-1:0] col,
                            input logic [TILE_W-1:0] row, input logic present);
      if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mip_level    <= lvl;
      req_tile_column  <= col;
      req_tile_row     <= row;
      req_tile_present <= present;
      do @(posedge clock); while (!req_ready);
      predict_tile_copies(lvl, col, row, present);
   endtask

   // Drop valid, drain every expected word, then give tiles with no expected word time to retire
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_GAP) @(posedge clock);
   endtask

   // Write all three registers back to back; only called while idle
   task automatic configure_map(input logic [MAP_W-1:0] wide, input logic [MAP_W-1:0] deep,
                                input logic [CAP_W-1:0] cap);
      csr_write <= 1'b1;
      csr_index <= CSR_MAP_WIDE;
      csr_data  <= CSR_W'(wide);
      @(posedge clock);
      csr_index <= CSR_MAP_DEEP;
      csr_data  <= CSR_W'(deep);
      @(posedge clock);
      csr_index <= CSR_BYTE_CAP;
      csr_data  <= CSR_W'(cap);
      @(posedge clock);
      csr_write <= 1'b0;
      map_wide = wide;
      map_deep = deep;
      byte_cap = cap;
      refresh_layout();
   endtask

   function automatic logic [MAP_W-1:0] random_side();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 4) return '0;
      if (pick < 14) return MAP_W'($urandom_range(MAX_TILES_SIDE + 1, 127));
      if (pick < 50) return MAP_W'($urandom_range(1, 8));
      return MAP_W'($urandom_range(1, MAX_TILES_SIDE));
   endfunction

   // Reset layout: one-tile map, every level, absent and outside tiles
   task automatic test_reset_layout();
      for (int l = 0; l < MIP_LEVELS; l++) send_tile(MIP_W'(l), '0, '0, 1'b1);
      send_tile(2'd0, '0, '0, 1'b0);
      send_tile(2'd0, 6'd1, '0, 1'b1);
      send_tile(2'd2, '0, 6'd1, 1'b1);
      send_tile(2'd3, 6'd63, 6'd63, 1'b0);
      settle();
   endtask

   // Largest, oversized and zero map sizes
   task automatic test_map_extremes();
      configure_map(7'd64, 7'd64, CAP_W'(FULL_CAP));
      send_tile(2'd0, 6'd63, 6'd63, 1'b1);
      send_tile(2'd3, 6'd63, 6'd63, 1'b1);
      send_tile(2'd1, 6'd0, 6'd0, 1'b1);
      send_tile(2'd2, 6'd63, 6'd0, 1'b1);
      send_tile(2'd0, 6'd0, 6'd63, 1'b1);
      send_tile(2'd0, 6'd63, 6'd63, 1'b0);
      settle();
      configure_map(7'd127, 7'd127, CAP_W'(DEFAULT_CAP));
      send_tile(2'd1, 6'd63, 6'd63, 1'b1);
      send_tile(2'd3, 6'd42, 6'd21, 1'b1);
      settle();
      configure_map(7'd0, 7'd5, CAP_W'(DEFAULT_CAP));
      send_tile(2'd0, 6'd0, 6'd0, 1'b1);
      settle();
      configure_map(7'd5, 7'd0, CAP_W'(DEFAULT_CAP));
      send_tile(2'd0, 6'd0, 6'd0, 1'b0);
      send_tile(2'd1, 6'd4, 6'd0, 1'b1);
      settle();
   endtask

   // Cap exactly at the total, one below it, and zero
   task automatic test_byte_cap();
      configure_map(7'd64, 7'd64, 23'd2785280);
      send_tile(2'd0, 6'd10, 6'd20, 1'b1);
      settle();
      configure_map(7'd64, 7'd64, 23'd2785279);
      send_tile(2'd0, 6'd0, 6'd0, 1'b1);
      send_tile(2'd1, 6'd3, 6'd3, 1'b0);
      settle();
      configure_map(7'd0, 7'd0, '0);
      send_tile(2'd0, 6'd0, 6'd0, 1'b1);
      settle();
   endtask

   // Mostly in-map tiles with random content under three random layouts
   task automatic test_random_traffic(input idle_mode_type mode, input int items);
      int unsigned       wide_eff, deep_eff, cap_pick;
      logic [TILE_W-1:0] col, row;
      set_idling(mode);
      for (int phase = 0; phase < 3; phase++) begin
         cap_pick = $urandom_range(0, 99);
         configure_map(random_side(), random_side(),
                       (cap_pick < 70) ? CAP_W'(DEFAULT_CAP) :
                       (cap_pick < 90) ? CAP_W'($urandom_range(0, FULL_CAP)) :
                       CAP_W'(FULL_CAP));
         wide_eff = clamp_side(map_wide);
         deep_eff = clamp_side(map_deep);
         for (int k = 0; k < items / 3; k++) begin
            col = (wide_eff != 0 && $urandom_range(0, 99) < 85) ?
                  TILE_W'($urandom_range(0, wide_eff - 1)) : TILE_W'($urandom_range(0, 63));
            row = (deep_eff != 0 && $urandom_range(0, 99) < 85) ?
                  TILE_W'($urandom_range(0, deep_eff - 1)) : TILE_W'($urandom_range(0, 63));
            send_tile(MIP_W'($urandom_range(0, 3)), col, row, $urandom_range(0, 99) < 88);
         end
         settle();
      end
   endtask

   // Hold the result side off while the sender keeps pushing full-size tiles
   task automatic test_back_pressure();
      set_idling(IDLE_NONE);
      configure_map(7'd16, 7'd16, CAP_W'(DEFAULT_CAP));
      hold_off_cycles = 300;
      for (int k = 0; k < 16; k++)
         send_tile(2'd0, TILE_W'($urandom_range(0, 15)), TILE_W'($urandom_range(0, 15)), 1'b1);
      settle();
   endtask

   initial begin
      refresh_layout();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      set_idling(IDLE_MIXED);
      test_reset_layout();
      test_map_extremes();
      test_byte_cap();
      test_random_traffic(IDLE_MIXED, 155);
      test_random_traffic(IDLE_SWAPPED, 155);
      test_random_traffic(IDLE_NONE, 150);
      test_back_pressure();
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
